### rtl/core/tpcrt_pkg.sv
// Package for the two-prime CRT reconstruction core: beat types and register codes.
// No dependencies; the core takes its names from here by scoped reference.
`default_nettype none

package tpcrt_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 62;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_P2_INVERSE_CONST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P1_INVERSE_CONST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_MODULUS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Q_LOG2           = 3'd5;

    // Largest meaningful q_log2; larger settings act as this one.
    localparam logic [5:0] Q_LOG2_MAX = 6'd32;

    // One input beat: the residue pair.
    typedef struct packed {
        logic signed [31:0] residue_one;
        logic signed [31:0] residue_two;
    } t_in_beat;

    // One output beat: centered value mod M and its centered reduction mod q.
    typedef struct packed {
        logic signed [62:0] combined_value;
        logic signed [31:0] reduced_coeff;
    } t_out_beat;

endpackage

`default_nettype wire

### rtl/core/two_prime_crt_reconstruct_core.sv
// Two-prime CRT reconstruction core: eight-stage pipeline plus configuration registers.
// Depends on tpcrt_pkg for beat types and register indexes.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ---------------------------------
// in        sink       i_in_valid / o_in_ready    i_in_data  (tpcrt_pkg::t_in_beat)
// out       source     o_out_valid / i_out_ready  o_out_data (tpcrt_pkg::t_out_beat)
// cfg       sink       i_cfg_we (no ready)        i_cfg_idx, i_cfg_data
//
// The core accepts one beat per clock cycle while the output side does not stall and
// carries each beat through stage registers 0 to 7 in order. The depth is set by the
// chain of two multiplier stages (quotient estimate, then estimate times modulus)
// followed by the wide reduction adds, each given a stage of its own.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults (product_modulus = 1, q_log2 = 32, the others zero).
// A stall on the output side holds each full stage in place, while empty stages
// ahead of it keep filling, so no beat is dropped or repeated.
module two_prime_crt_reconstruct_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tpcrt_pkg::t_in_beat               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tpcrt_pkg::t_out_beat                   o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [tpcrt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tpcrt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NSTG = 8;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [61:0] r_p2_inverse_const;
    logic [31:0] r_threshold_one;
    logic [61:0] r_p1_inverse_const;
    logic [31:0] r_threshold_two;
    logic [61:0] r_product_modulus;
    logic [5:0]  r_q_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_inverse_const <= '0;
            r_threshold_one    <= '0;
            r_p1_inverse_const <= '0;
            r_threshold_two    <= '0;
            r_product_modulus  <= 62'd1;
            r_q_log2           <= tpcrt_pkg::Q_LOG2_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpcrt_pkg::REG_P2_INVERSE_CONST: r_p2_inverse_const <= i_cfg_data;
                tpcrt_pkg::REG_THRESHOLD_ONE:    r_threshold_one    <= i_cfg_data[31:0];
                tpcrt_pkg::REG_P1_INVERSE_CONST: r_p1_inverse_const <= i_cfg_data;
                tpcrt_pkg::REG_THRESHOLD_TWO:    r_threshold_two    <= i_cfg_data[31:0];
                tpcrt_pkg::REG_PRODUCT_MODULUS:  r_product_modulus  <= i_cfg_data;
                tpcrt_pkg::REG_Q_LOG2:           r_q_log2           <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Values derived from the registers. The user must write the registers only while the
    // core is idle (the core does not enforce this), so they can feed the stages directly.
    logic [63:0] w_m64;
    logic [63:0] w_m_minus1;
    logic [63:0] w_off;
    logic [63:0] w_off_m1;
    logic [63:0] w_off_p1;
    logic [5:0]  w_ql;
    logic [32:0] w_q33;
    logic [31:0] w_qmask;
    logic [31:0] w_half;

    always_comb begin
        w_m64      = {2'b00, r_product_modulus};
        w_m_minus1 = w_m64 - 64'd1;
        // Arithmetic shift right by one; a zero modulus gives an offset of -1.
        w_off      = {w_m_minus1[63], w_m_minus1[63:1]};
        w_off_m1   = w_off - 64'd1;
        w_off_p1   = w_off + 64'd1;
        w_ql       = (r_q_log2 > tpcrt_pkg::Q_LOG2_MAX) ? tpcrt_pkg::Q_LOG2_MAX : r_q_log2;
        w_q33      = 33'd1 << w_ql;
        w_qmask    = w_q33[31:0] - 32'd1;
        w_half     = w_q33[32:1];
    end

    // ------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when the stage
    // after it moves on this cycle.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    always_comb begin
        w_adv[NSTG] = i_out_ready;
        for (int s = NSTG - 1; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    assign o_in_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: residue times CRT constant (constant split into two 31-bit
    // halves) and residue times threshold for the quotient estimate.
    // Lane 0 handles residue_one, lane 1 residue_two.
    // ------------------------------------------------------------------
    logic signed [31:0] w_x  [2];
    logic [61:0]        w_k  [2];
    logic [31:0]        w_t  [2];
    logic [63:0]        w_pk_lo [2];
    logic [63:0]        w_pk_hi [2];
    logic [64:0]        w_pt    [2];

    logic [63:0]        r_s0_pk_lo [2];
    logic [63:0]        r_s0_pk_hi [2];
    logic signed [31:0] r_s0_v     [2];

    always_comb begin
        w_x[0] = i_in_data.residue_one;
        w_x[1] = i_in_data.residue_two;
        w_k[0] = r_p2_inverse_const;
        w_k[1] = r_p1_inverse_const;
        w_t[0] = r_threshold_one;
        w_t[1] = r_threshold_two;
        for (int l = 0; l < 2; l++) begin
            w_pk_lo[l] = w_x[l] * $signed({1'b0, w_k[l][30:0]});
            w_pk_hi[l] = w_x[l] * $signed({1'b0, w_k[l][61:31]});
            w_pt[l]    = w_x[l] * $signed({1'b0, w_t[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int l = 0; l < 2; l++) begin
                r_s0_pk_lo[l] <= w_pk_lo[l];
                r_s0_pk_hi[l] <= w_pk_hi[l];
                // Quotient estimate: bits 63..32 of the product, as a signed word.
                r_s0_v[l]     <= $signed(w_pt[l][63:32]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: quotient estimate times the modulus (split like stage 0),
    // and the two halves of x*K folded together.
    // ------------------------------------------------------------------
    logic [63:0] w_vm_lo [2];
    logic [63:0] w_vm_hi [2];
    logic [63:0] r_s1_xk    [2];
    logic [63:0] r_s1_vm_lo [2];
    logic [63:0] r_s1_vm_hi [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_vm_lo[l] = r_s0_v[l] * $signed({1'b0, r_product_modulus[30:0]});
            w_vm_hi[l] = r_s0_v[l] * $signed({1'b0, r_product_modulus[61:31]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_s1_xk[l]    <= r_s0_pk_lo[l] + (r_s0_pk_hi[l] << 31);
                r_s1_vm_lo[l] <= w_vm_lo[l];
                r_s1_vm_hi[l] <= w_vm_hi[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-lane term x*K - v*M, wrapping at 64 bits.
    // ------------------------------------------------------------------
    logic [63:0] r_s2_term [2];

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_s2_term[l] <= r_s1_xk[l] - r_s1_vm_lo[l] - (r_s1_vm_hi[l] << 31);
            end
        end
    end

    // Stage 3: sum of the two terms.
    logic [63:0] r_s3_c;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s3_c <= r_s2_term[0] + r_s2_term[1];
        end
    end

    // Stage 4: sign-based reduction, +M when negative and -M otherwise.
    logic [63:0] r_s4_c;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s4_c <= r_s3_c[63] ? (r_s3_c + w_m64) : (r_s3_c - w_m64);
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 and 6: centering. Stage 5 takes the two range compares as
    // sign bits, stage 6 applies the resulting correction.
    // ------------------------------------------------------------------
    logic [63:0] w_lo_chk;
    logic [63:0] w_hi_chk;
    logic [63:0] r_s5_c;
    logic        r_s5_neg;
    logic        r_s5_pos;

    assign w_lo_chk = r_s4_c + w_off_m1;
    assign w_hi_chk = r_s4_c - w_off_p1;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s5_c   <= r_s4_c;
            r_s5_neg <= w_lo_chk[63];
            r_s5_pos <= w_hi_chk[63];
        end
    end

    logic [63:0] w_adj;
    logic [63:0] r_s6_c;

    assign w_adj = (r_s5_neg ? w_m64 : 64'd0) - (r_s5_pos ? 64'd0 : w_m64);

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_s6_c <= r_s5_c + w_adj;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: centered reduction mod q on the low word; output register.
    // ------------------------------------------------------------------
    logic [31:0]          w_red;
    tpcrt_pkg::t_out_beat r_s7_out;

    assign w_red = ((r_s6_c[31:0] + w_half) & w_qmask) - w_half;

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_s7_out.combined_value <= $signed(r_s6_c[62:0]);
            r_s7_out.reduced_coeff  <= $signed(w_red);
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_s7_out;

`ifndef SYNTHESIS
    // An empty output register means nothing upstream can be blocked.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while the output register is empty");

    // A free output side lets the whole pipeline advance.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input blocked while the output side is ready");

    // The centered reduction keeps the parity of the combined value for q >= 2.
    a_parity_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (w_ql != 6'd0))
            |-> (o_out_data.reduced_coeff[0] == o_out_data.combined_value[0]))
        else $error("reduced coefficient parity differs from combined value");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
